// ----- rtl/core/crc_remainder_division_assert.svh -----
// Assertion macros for the CRC long-division block.
// Used by the top level; needs nothing else.
`ifndef CRC_REMAINDER_DIVISION_ASSERT_SVH
`define CRC_REMAINDER_DIVISION_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CRC_RD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crc_rd assertion failed");

// Next-cycle implication, disabled during reset
`define CRC_RD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crc_rd assertion failed");

`endif

// ----- rtl/core/crc_rd_pkg.sv -----
// Shared constants and types for the CRC long-division block.
// No dependencies.
`timescale 1ns / 1ps

package crc_rd_pkg;

  localparam int MAX_DEGREE    = 32;
  localparam int BITS_PER_ITEM = 8;
  localparam int DEG_W         = 6;
  localparam int CNT_W         = 4;
  localparam int IDX_W         = 2;
  localparam int CFG_DATA_W    = 32;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_POLY_DEGREE = 2'd0;
  localparam logic [IDX_W-1:0] REG_POLY_TAPS   = 2'd1;

  // Reset generator: x^4 + x^2 + 1
  localparam logic [DEG_W-1:0]      RESET_DEGREE = 6'd4;
  localparam logic [MAX_DEGREE-1:0] RESET_TAPS   = 32'd5;

  // Generator as the divider sees it
  typedef struct packed {
    logic [MAX_DEGREE-1:0] top_bit;  // one-hot at position degree-1
    logic [MAX_DEGREE-1:0] mask;     // degree low bits set
    logic [MAX_DEGREE-1:0] taps;     // coefficients below the leading one, masked
  } gen_t;

endpackage

// ----- rtl/core/crc_rd_if.sv -----
// Valid/ready channel interfaces for the CRC long-division block.
// Depends on crc_rd_pkg.
`timescale 1ns / 1ps

// Input item: frame bits, first bit in the MSB
interface crc_rd_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [crc_rd_pkg::BITS_PER_ITEM-1:0]     data_bits;
  logic [crc_rd_pkg::CNT_W-1:0]             bit_count;
  logic                                     last;

  modport source (output valid, data_bits, bit_count, last, input ready);
  modport sink   (input valid, data_bits, bit_count, last, output ready);
endinterface

// Result item: remainder and error flag
interface crc_rd_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [crc_rd_pkg::MAX_DEGREE-1:0]        remainder;
  logic                                     nonzero;

  modport source (output valid, remainder, nonzero, input ready);
  modport sink   (input valid, remainder, nonzero, output ready);
endinterface

// ----- rtl/core/crc_rd_cfg.sv -----
// Configuration registers: holds the generator and derives its mask and top bit.
// Depends on crc_rd_pkg.
`timescale 1ns / 1ps

module crc_rd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crc_rd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [crc_rd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output crc_rd_pkg::gen_t                    gen
);

  logic [crc_rd_pkg::MAX_DEGREE-1:0] top_bit;
  logic [crc_rd_pkg::MAX_DEGREE-1:0] mask;
  logic [crc_rd_pkg::MAX_DEGREE-1:0] taps;
  logic [crc_rd_pkg::MAX_DEGREE-1:0] top_bit_next;
  logic [crc_rd_pkg::DEG_W-1:0]      deg_raw;
  logic [crc_rd_pkg::DEG_W-1:0]      deg_eff;
  logic [crc_rd_pkg::DEG_W-1:0]      deg_m1;

  // Clamp the written degree into 1..MAX_DEGREE, then place the top bit
  always_comb begin
    deg_raw = cfg_data[crc_rd_pkg::DEG_W-1:0];
    if (deg_raw == '0) begin
      deg_eff = crc_rd_pkg::DEG_W'(1);
    end else if (deg_raw > crc_rd_pkg::DEG_W'(crc_rd_pkg::MAX_DEGREE)) begin
      deg_eff = crc_rd_pkg::DEG_W'(crc_rd_pkg::MAX_DEGREE);
    end else begin
      deg_eff = deg_raw;
    end
    deg_m1       = deg_eff - crc_rd_pkg::DEG_W'(1);
    top_bit_next = crc_rd_pkg::MAX_DEGREE'(1) << deg_m1;
  end

  // Register writes; mask is kept alongside the one-hot top bit
  always_ff @(posedge clk) begin
    if (rst) begin
      top_bit <= crc_rd_pkg::MAX_DEGREE'(1) << (crc_rd_pkg::RESET_DEGREE - 1'b1);
      mask    <= (crc_rd_pkg::MAX_DEGREE'(1) << crc_rd_pkg::RESET_DEGREE)
                 - crc_rd_pkg::MAX_DEGREE'(1);
      taps    <= crc_rd_pkg::RESET_TAPS;
    end else if (cfg_we) begin
      case (cfg_index)
        crc_rd_pkg::REG_POLY_DEGREE: begin
          top_bit <= top_bit_next;
          mask    <= top_bit_next | (top_bit_next - crc_rd_pkg::MAX_DEGREE'(1));
        end
        crc_rd_pkg::REG_POLY_TAPS: begin
          taps <= cfg_data[crc_rd_pkg::MAX_DEGREE-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign gen.top_bit = top_bit;
  assign gen.mask    = mask;
  assign gen.taps    = taps & mask;

endmodule

// ----- rtl/core/crc_rd_step.sv -----
// Divider step: feeds up to one item's worth of bits into the remainder.
// Depends on crc_rd_pkg.
`timescale 1ns / 1ps

module crc_rd_step (
  input  crc_rd_pkg::gen_t                        gen,
  input  logic [crc_rd_pkg::MAX_DEGREE-1:0]       rem_in,
  input  logic [crc_rd_pkg::BITS_PER_ITEM-1:0]    data_bits,
  input  logic [crc_rd_pkg::CNT_W-1:0]            bit_count,
  output logic [crc_rd_pkg::MAX_DEGREE-1:0]       rem_out
);

  logic [crc_rd_pkg::CNT_W-1:0]      cnt;
  logic [crc_rd_pkg::MAX_DEGREE-1:0] r;
  logic                              top;
  logic                              din;

  // One shift/subtract per bit, MSB first, unrolled across the item
  always_comb begin
    if (bit_count > crc_rd_pkg::CNT_W'(crc_rd_pkg::BITS_PER_ITEM)) begin
      cnt = crc_rd_pkg::CNT_W'(crc_rd_pkg::BITS_PER_ITEM);
    end else begin
      cnt = bit_count;
    end
    r = rem_in;
    for (int k = 0; k < crc_rd_pkg::BITS_PER_ITEM; k++) begin
      top = |(r & gen.top_bit);
      din = data_bits[crc_rd_pkg::BITS_PER_ITEM-1-k];
      if (crc_rd_pkg::CNT_W'(k) < cnt) begin
        r = ({r[crc_rd_pkg::MAX_DEGREE-2:0], din}) & gen.mask;
        if (top) begin
          r = r ^ gen.taps;
        end
      end
    end
    rem_out = r;
  end

endmodule

// ----- rtl/core/crc_remainder_division.sv -----
// Each accepted item is registered; as it leaves the input register its bits are
// divided into the running remainder, and on the last item of a frame the
// remainder and its nonzero flag land in the output register. One item is taken
// every cycle unless a last item waits on a held result; the remainder update,
// eight shift/XOR steps unrolled between the input register and the remainder
// register, sets that pace. Items that are not last give no result and never
// wait on the output side. Write the generator only while no frame is in flight.
// Depends on crc_rd_pkg, crc_rd_if, crc_rd_cfg, crc_rd_step and the assert macros.
`timescale 1ns / 1ps
`include "crc_remainder_division_assert.svh"

module crc_remainder_division (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crc_rd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [crc_rd_pkg::CFG_DATA_W-1:0]   cfg_data,
  crc_rd_in_if.sink                           in_item,
  crc_rd_out_if.source                        out_item
);

  crc_rd_pkg::gen_t                        gen;
  logic                                    s1_valid;
  logic [crc_rd_pkg::BITS_PER_ITEM-1:0]    s1_data;
  logic [crc_rd_pkg::CNT_W-1:0]            s1_count;
  logic                                    s1_last;
  logic                                    s1_adv;
  logic                                    in_ready;
  logic [crc_rd_pkg::MAX_DEGREE-1:0]       rem_q;
  logic [crc_rd_pkg::MAX_DEGREE-1:0]       rem_next;
  logic                                    out_valid;
  logic [crc_rd_pkg::MAX_DEGREE-1:0]       out_rem;
  logic                                    out_nz;

  crc_rd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gen       (gen)
  );

  crc_rd_step u_step (
    .gen       (gen),
    .rem_in    (rem_q),
    .data_bits (s1_data),
    .bit_count (s1_count),
    .rem_out   (rem_next)
  );

  // Stage item moves on unless it is last and the result slot is held
  assign s1_adv   = s1_valid && (!s1_last || !out_valid || out_item.ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_item.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_item.valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_ready) begin
      s1_data  <= in_item.data_bits;
      s1_count <= in_item.bit_count;
      s1_last  <= in_item.last;
    end
  end

  // Running remainder, cleared at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      rem_q <= '0;
    end else if (s1_adv) begin
      rem_q <= s1_last ? '0 : rem_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_rem <= rem_next & gen.mask;
      out_nz  <= |(rem_next & gen.mask);
    end
  end

  assign out_item.valid     = out_valid;
  assign out_item.remainder = out_rem;
  assign out_item.nonzero   = out_nz;

  // Checks
  `CRC_RD_ASSERT_NOW(a_top_onehot, clk, rst, 1'b1, $onehot(gen.top_bit))
  `CRC_RD_ASSERT_NOW(a_mask_shape, clk, rst, 1'b1,
                     gen.mask == (gen.top_bit | (gen.top_bit - 32'd1)))
  `CRC_RD_ASSERT_NEXT(a_clear_after_last, clk, rst, s1_adv && s1_last, rem_q == '0)
  `CRC_RD_ASSERT_NEXT(a_no_spurious_result, clk, rst,
                      !(s1_valid && s1_last) && (!out_valid || out_item.ready),
                      !out_valid)

endmodule
